[rtl/frustum_cull_test_unit_assert.svh]
// Assertion macros used by the frustum culling top module.
`ifndef FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
`define FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum cull assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum cull assertion failed");

`endif

[rtl/cft_pkg.sv]
`timescale 1ns / 1ps
package cft_pkg;

  localparam int NUM_PLANES = 6;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_NEAR   = 3'd0;
  localparam logic [2:0] REG_FAR    = 3'd1;
  localparam logic [2:0] REG_RIGHT  = 3'd2;
  localparam logic [2:0] REG_LEFT   = 3'd3;
  localparam logic [2:0] REG_TOP    = 3'd4;
  localparam logic [2:0] REG_BOTTOM = 3'd5;

  typedef logic signed [15:0] fx16_t;  // Q8.8 or Q2.14 value
  typedef logic signed [32:0] scp_t;   // scaled coordinate, 16 fraction bits
  typedef logic signed [23:0] rme_t;   // matrix entry, 16 fraction bits
  typedef logic signed [47:0] wd_t;    // world coordinate, 16 fraction bits
  typedef logic [63:0] plane_t;

  typedef struct packed {
    logic                  sphere;
    rme_t [2:0][2:0]       rm;
    scp_t [2:0]            sa;
    scp_t [2:0]            sb;
    fx16_t [2:0]           tr;
    logic [31:0]           lim;
  } front_t;

  typedef struct packed {
    logic        sphere;
    wd_t [2:0]   lo;
    wd_t [2:0]   hi;
    logic [31:0] lim;
  } wbox_t;

  // Coordinate i of a packed 48-bit triple: x in 47:32, y in 31:16, z in 15:0.
  function automatic fx16_t fld3(input logic [47:0] v, input int unsigned i);
    fx16_t r;
    r = $signed(v[47-16*i -: 16]);
    return r;
  endfunction

endpackage

[rtl/cft_front.sv]
`timescale 1ns / 1ps
module cft_front import cft_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic        sphere,
  input  logic [47:0] lo_corner,
  input  logic [47:0] hi_corner,
  input  logic [15:0] radius,
  input  logic [63:0] rotation,
  input  logic [47:0] translation,
  input  logic [47:0] scale,
  output front_t      front
);

  localparam logic signed [35:0] ONE28 = 36'sh010000000;
  localparam logic signed [35:0] HALF12 = 36'sd2048;

  logic signed [31:0] qp_r [9];
  logic signed [31:0] qp_nxt [9];
  scp_t [2:0] sa_r, sb_r, sa_nxt, sb_nxt;
  fx16_t [2:0] tr1_r, tr2_r;
  logic [15:0] rad_r, ms_r, ms_nxt;
  logic sph1_r, sph2_r;
  rme_t [2:0][2:0] rm_r, rm_nxt;
  scp_t [2:0] sa2_r, sb2_r;
  logic [31:0] lim_r;

  fx16_t qw, qx, qy, qz;
  logic signed [35:0] r28 [3][3];
  logic signed [35:0] e [9];
  logic signed [35:0] rr;
  logic [47:0] b_src;

  // Stage 1: quaternion products, scaled corners, largest scale.
  always_comb begin
    qw = $signed(rotation[63:48]);
    qx = $signed(rotation[47:32]);
    qy = $signed(rotation[31:16]);
    qz = $signed(rotation[15:0]);
    qp_nxt[0] = qy * qy;
    qp_nxt[1] = qz * qz;
    qp_nxt[2] = qx * qx;
    qp_nxt[3] = qx * qy;
    qp_nxt[4] = qw * qz;
    qp_nxt[5] = qx * qz;
    qp_nxt[6] = qw * qy;
    qp_nxt[7] = qy * qz;
    qp_nxt[8] = qw * qx;
    // A sphere is a box whose two corners coincide.
    b_src = sphere ? lo_corner : hi_corner;
    for (int i = 0; i < 3; i++) begin
      sa_nxt[i] = $signed({1'b0, scale[47-16*i -: 16]}) * fld3(lo_corner, i);
      sb_nxt[i] = $signed({1'b0, scale[47-16*i -: 16]}) * fld3(b_src, i);
    end
    ms_nxt = scale[47:32];
    if (scale[31:16] > ms_nxt) ms_nxt = scale[31:16];
    if (scale[15:0] > ms_nxt) ms_nxt = scale[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) qp_r[k] <= qp_nxt[k];
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      for (int i = 0; i < 3; i++) tr1_r[i] <= fld3(translation, i);
      rad_r <= radius;
      ms_r <= ms_nxt;
      sph1_r <= sphere;
    end
  end

  // Stage 2: matrix entries with 28 fraction bits, rounded to 16; radius times largest scale.
  always_comb begin
    for (int k = 0; k < 9; k++) e[k] = 36'(qp_r[k]);
    r28[0][0] = ONE28 - ((e[0] + e[1]) <<< 1);
    r28[0][1] = (e[3] - e[4]) <<< 1;
    r28[0][2] = (e[5] + e[6]) <<< 1;
    r28[1][0] = (e[3] + e[4]) <<< 1;
    r28[1][1] = ONE28 - ((e[2] + e[1]) <<< 1);
    r28[1][2] = (e[7] - e[8]) <<< 1;
    r28[2][0] = (e[5] - e[6]) <<< 1;
    r28[2][1] = (e[7] + e[8]) <<< 1;
    r28[2][2] = ONE28 - ((e[2] + e[0]) <<< 1);
    rr = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rr = r28[i][j] + HALF12;
        rm_nxt[i][j] = $signed(rr[35:12]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r <= rm_nxt;
      sa2_r <= sa_r;
      sb2_r <= sb_r;
      tr2_r <= tr1_r;
      lim_r <= rad_r * ms_r;
      sph2_r <= sph1_r;
    end
  end

  always_comb begin
    front.sphere = sph2_r;
    front.rm = rm_r;
    front.sa = sa2_r;
    front.sb = sb2_r;
    front.tr = tr2_r;
    front.lim = lim_r;
  end

endmodule

[rtl/cft_xform.sv]
`timescale 1ns / 1ps
module cft_xform import cft_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  front_t front,
  output wbox_t  wbox
);

  logic signed [56:0] ta_r [3][3];
  logic signed [56:0] tb_r [3][3];
  fx16_t [2:0] tr_r;
  logic [31:0] lim3_r, lim4_r;
  logic sph3_r, sph4_r;
  wd_t [2:0] lo_r, hi_r, lo_nxt, hi_nxt;

  logic signed [63:0] acc_lo, acc_hi, ta, tb;

  // Stage 3: every matrix entry times both candidate coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ta_r[i][j] <= $signed(front.rm[i][j]) * $signed(front.sa[j]);
          tb_r[i][j] <= $signed(front.rm[i][j]) * $signed(front.sb[j]);
        end
      end
      tr_r <= front.tr;
      lim3_r <= front.lim;
      sph3_r <= front.sphere;
    end
  end

  // Stage 4: each term picks its corner independently, so the extreme sums
  // bound all eight corners; rounding is monotonic and commutes with them.
  always_comb begin
    acc_lo = '0;
    acc_hi = '0;
    ta = '0;
    tb = '0;
    for (int i = 0; i < 3; i++) begin
      acc_lo = 64'($signed(tr_r[i])) <<< 24;
      acc_hi = acc_lo;
      for (int j = 0; j < 3; j++) begin
        ta = 64'(ta_r[i][j]);
        tb = 64'(tb_r[i][j]);
        acc_lo = acc_lo + ((ta < tb) ? ta : tb);
        acc_hi = acc_hi + ((ta < tb) ? tb : ta);
      end
      acc_lo = acc_lo + 64'sd32768;
      acc_hi = acc_hi + 64'sd32768;
      lo_nxt[i] = $signed(acc_lo[63:16]);
      hi_nxt[i] = $signed(acc_hi[63:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      lim4_r <= lim3_r;
      sph4_r <= sph3_r;
    end
  end

  always_comb begin
    wbox.sphere = sph4_r;
    wbox.lo = lo_r;
    wbox.hi = hi_r;
    wbox.lim = lim4_r;
  end

endmodule

[rtl/cft_plane.sv]
`timescale 1ns / 1ps
module cft_plane import cft_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  wbox_t                      wbox,
  input  plane_t [NUM_PLANES-1:0]    planes,
  output logic                       visible
);

  logic signed [63:0] prod_r [NUM_PLANES][3];
  logic signed [63:0] prod_nxt [NUM_PLANES][3];
  fx16_t d_r [NUM_PLANES];
  logic [31:0] lim_r;
  logic sph_r;
  logic visible_r, visible_nxt;

  fx16_t n;
  wd_t sel;
  logic signed [63:0] pdist, thr;

  // Stage 5: normal times the positive vertex, per plane and axis.
  always_comb begin
    n = '0;
    sel = '0;
    for (int k = 0; k < NUM_PLANES; k++) begin
      for (int i = 0; i < 3; i++) begin
        n = $signed(planes[k][63-16*i -: 16]);
        sel = (n < 0) ? wbox.lo[i] : wbox.hi[i];
        prod_nxt[k][i] = n * sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        for (int i = 0; i < 3; i++) prod_r[k][i] <= prod_nxt[k][i];
        d_r[k] <= $signed(planes[k][15:0]);
      end
      lim_r <= wbox.lim;
      sph_r <= wbox.sphere;
    end
  end

  // Stage 6: signed distances against the threshold.
  always_comb begin
    pdist = '0;
    thr = sph_r ? -$signed({18'd0, lim_r, 14'd0}) : 64'sd0;
    visible_nxt = 1'b1;
    for (int k = 0; k < NUM_PLANES; k++) begin
      pdist = prod_r[k][0] + prod_r[k][1] + prod_r[k][2] + (64'(d_r[k]) <<< 22);
      if (pdist < thr) visible_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) visible_r <= visible_nxt;
  end

  assign visible = visible_r;

endmodule

[rtl/frustum_cull_test_unit.sv]
// An accepted item passes through six registered stages; out_valid rises
// when it reaches the last one, and any stall holds every stage in place.
// Throughput: one item per cycle through the six-stage pipeline unless
// stalled; the widest step is the matrix-by-scaled-point multiply stage.
// Reset (synchronous, rst_n low) clears all six planes to zero and empties
// the pipeline; no result is lost or repeated under stall.
`timescale 1ns / 1ps
`include "frustum_cull_test_unit_assert.svh"
module frustum_cull_test_unit import cft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [47:0] in_center_or_low_corner,
  input  logic [47:0] in_high_corner,
  input  logic [15:0] in_radius,
  input  logic [63:0] in_rotation,
  input  logic [47:0] in_translation,
  input  logic [47:0] in_scale,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_visible,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int DEPTH = 6;

  plane_t [NUM_PLANES-1:0] plane_r;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic en, accept;
  front_t front;
  wbox_t wbox;

  // The whole pipeline advances together unless a finished item sits in the
  // last stage and the consumer holds it off. Bubbles travel as cleared
  // valid bits alongside the data registers.
  assign en = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign accept = in_valid && !in_stall;
  assign out_valid = vld_r[DEPTH-1];
  assign cfg_ready = 1'b1;

  always_comb begin
    vld_nxt = en ? {vld_r[DEPTH-2:0], accept} : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Plane registers. Indexes past the bottom plane are accepted and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NEAR:   plane_r[0] <= cfg_data;
        REG_FAR:    plane_r[1] <= cfg_data;
        REG_RIGHT:  plane_r[2] <= cfg_data;
        REG_LEFT:   plane_r[3] <= cfg_data;
        REG_TOP:    plane_r[4] <= cfg_data;
        REG_BOTTOM: plane_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stages one and two: rotation matrix, scaled corners, sphere radius bound.
  cft_front u_front (
    .clk         (clk),
    .en          (en),
    .sphere      (in_action),
    .lo_corner   (in_center_or_low_corner),
    .hi_corner   (in_high_corner),
    .radius      (in_radius),
    .rotation    (in_rotation),
    .translation (in_translation),
    .scale       (in_scale),
    .front       (front)
  );

  // Stages three and four: world-space bounding box.
  cft_xform u_xform (
    .clk   (clk),
    .en    (en),
    .front (front),
    .wbox  (wbox)
  );

  // Stages five and six: plane distances and the visibility decision.
  cft_plane u_plane (
    .clk     (clk),
    .en      (en),
    .wbox    (wbox),
    .planes  (plane_r),
    .visible (out_visible)
  );

  `CFT_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)
  `CFT_ASSERT_NEXT(a_accept_enters, clk, rst_n, accept, vld_r[0])
  `CFT_ASSERT_NEXT(a_frozen_holds, clk, rst_n, !en, $stable(vld_r))

endmodule

[verif/frustum_cull_checker.sv]
`timescale 1ns / 1ps
module frustum_cull_checker import cft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [47:0] in_center_or_low_corner,
  input  logic [47:0] in_high_corner,
  input  logic [15:0] in_radius,
  input  logic [63:0] in_rotation,
  input  logic [47:0] in_translation,
  input  logic [47:0] in_scale,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_visible,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  plane_t planes [NUM_PLANES];
  logic   visible_q [$];
  longint mtx [9];
  longint scl [3];
  longint trn [3];

  function automatic longint s16(input logic [63:0] v, input int sh);
    logic signed [15:0] f;
    f = v[sh +: 16];
    return longint'(f);
  endfunction

  // One world coordinate of a packed object-space point, 16 fraction bits.
  function automatic longint world_coord(input logic [47:0] pt, input int i);
    longint acc;
    acc = mtx[3*i] * (scl[0] * s16(pt, 32)) + mtx[3*i+1] * (scl[1] * s16(pt, 16))
        + mtx[3*i+2] * (scl[2] * s16(pt, 0)) + trn[i] * 64'sd16777216;
    return (acc + 64'sd32768) >>> 16;
  endfunction

  // Signed plane distance with 30 fraction bits.
  function automatic longint plane_dist(input plane_t pl, input longint p0,
                                        input longint p1, input longint p2);
    return s16(pl, 48) * p0 + s16(pl, 32) * p1 + s16(pl, 16) * p2
         + s16(pl, 0) * 64'sd4194304;
  endfunction

  function automatic logic predict_visible(
    input logic act, input logic [47:0] pa, input logic [47:0] pb,
    input logic [15:0] rad, input logic [63:0] rot, input logic [47:0] tr,
    input logic [47:0] sc);
    longint qw, qx, qy, qz, one, ms, lim;
    longint r [9];
    longint c [3];
    longint lo [3];
    longint hi [3];
    longint w;
    logic [47:0] corner;
    logic vis;
    qw = s16(rot, 48); qx = s16(rot, 32); qy = s16(rot, 16); qz = s16(rot, 0);
    one = 64'sd1 << 28;
    r[0] = one - 2 * (qy * qy + qz * qz);
    r[1] = 2 * (qx * qy - qw * qz);
    r[2] = 2 * (qx * qz + qw * qy);
    r[3] = 2 * (qx * qy + qw * qz);
    r[4] = one - 2 * (qx * qx + qz * qz);
    r[5] = 2 * (qy * qz - qw * qx);
    r[6] = 2 * (qx * qz - qw * qy);
    r[7] = 2 * (qy * qz + qw * qx);
    r[8] = one - 2 * (qx * qx + qy * qy);
    for (int k = 0; k < 9; k++) mtx[k] = (r[k] + 64'sd2048) >>> 12;
    for (int i = 0; i < 3; i++) begin
      scl[i] = longint'(sc[47-16*i -: 16]);
      trn[i] = s16({16'b0, tr}, 32 - 16 * i);
    end
    vis = 1'b1;
    if (act) begin
      for (int i = 0; i < 3; i++) c[i] = world_coord(pa, i);
      ms = scl[0];
      if (scl[1] > ms) ms = scl[1];
      if (scl[2] > ms) ms = scl[2];
      lim = longint'(rad) * ms * 64'sd16384;
      for (int j = 0; j < NUM_PLANES; j++)
        if (plane_dist(planes[j], c[0], c[1], c[2]) < -lim) vis = 1'b0;
    end else begin
      // The world box encloses all eight transformed corners.
      for (int k = 0; k < 8; k++) begin
        for (int i = 0; i < 3; i++)
          corner[47-16*i -: 16] = ((k >> i) & 1) ? pb[47-16*i -: 16] : pa[47-16*i -: 16];
        for (int i = 0; i < 3; i++) begin
          w = world_coord(corner, i);
          if (k == 0 || w < lo[i]) lo[i] = w;
          if (k == 0 || w > hi[i]) hi[i] = w;
        end
      end
      for (int j = 0; j < NUM_PLANES; j++)
        if (plane_dist(planes[j],
                       s16(planes[j], 48) < 0 ? lo[0] : hi[0],
                       s16(planes[j], 32) < 0 ? lo[1] : hi[1],
                       s16(planes[j], 16) < 0 ? lo[2] : hi[2]) < 0)
          vis = 1'b0;
    end
    return vis;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
    for (int j = 0; j < NUM_PLANES; j++) planes[j] = '0;
  end

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      for (int j = 0; j < NUM_PLANES; j++) planes[j] = '0;
      visible_q.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_PLANES) planes[cfg_index] = cfg_data;
      if (in_valid && !in_stall)
        visible_q.push_back(predict_visible(in_action, in_center_or_low_corner,
                                            in_high_corner, in_radius, in_rotation,
                                            in_translation, in_scale));
      if (out_valid && !out_stall) begin
        if (visible_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result: visible=%0d", out_visible);
          mismatches = mismatches + 1;
        end else begin
          want = visible_q.pop_front();
          if (want !== out_visible) begin
            if (mismatches < 10)
              $display("visible mismatch at %0t: expected %0d, got %0d",
                       $time, want, out_visible);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    outstanding = visible_q.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import cft_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  // The drain waits this long after the last expected result has arrived.
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [47:0] in_center_or_low_corner = '0;
  logic [47:0] in_high_corner = '0;
  logic [15:0] in_radius = '0;
  logic [63:0] in_rotation = '0;
  logic [47:0] in_translation = '0;
  logic [47:0] in_scale = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_visible;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_NEAR;
  logic [63:0] cfg_data = '0;
  int          mismatches;
  int          outstanding;
  int          cycles = 0;
  logic        hold_req = 1'b0;

  // The clock has a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frustum_cull_test_unit uut (.*);

  frustum_cull_checker chk (.*);

  // A run that hangs anywhere is ended here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver stalls in runs of random length. Most runs are short, a few
  // are long, and some are stretches with no stall at all. Once the stimulus
  // asks for it, the receiver holds off for a long stretch so that the
  // pipeline fills and pushes back on the input.
  always @(posedge clk) begin
    static int run_left = 0;
    static logic run_stall = 1'b0;
    static logic hold_done = 1'b0;
    int r;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      run_left = 300;
      run_stall = 1'b1;
    end else if (run_left > 0) begin
      run_left = run_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        run_stall = 1'b0;
        run_left = $urandom_range(0, 3);
      end else if (r < 75) begin
        run_stall = 1'b1;
        run_left = $urandom_range(0, 2);
      end else if (r < 95) begin
        run_stall = 1'b0;
        run_left = $urandom_range(20, 60);
      end else begin
        run_stall = 1'b1;
        run_left = $urandom_range(15, 50);
      end
    end
    out_stall <= rst_n ? run_stall : 1'b0;
  end

  function automatic logic [63:0] plane_of(input int nx, input int ny, input int nz,
                                           input int d);
    return {16'(nx), 16'(ny), 16'(nz), 16'(d)};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A coordinate triple inside a cube of the given half size, in whole units.
  function automatic logic [47:0] near_point(input int span);
    int hs;
    hs = span * 256;
    return {16'($urandom_range(0, 2 * hs) - hs), 16'($urandom_range(0, 2 * hs) - hs),
            16'($urandom_range(0, 2 * hs) - hs)};
  endfunction

  // A roughly unit quaternion from a random direction in four dimensions.
  function automatic logic [63:0] unit_quat();
    real q [4];
    real norm;
    logic [63:0] packed_q;
    norm = 0.0;
    for (int i = 0; i < 4; i++) begin
      q[i] = $urandom_range(0, 2000) / 1000.0 - 1.0;
      norm = norm + q[i] * q[i];
    end
    if (norm < 0.0001) return {16'd16384, 48'd0};
    norm = $sqrt(norm);
    for (int i = 0; i < 4; i++) packed_q[63-16*i -: 16] = 16'($rtoi(q[i] / norm * 16384.0));
    return packed_q;
  endfunction

  task automatic write_plane(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_frustum(input logic [63:0] pn, input logic [63:0] pf,
                               input logic [63:0] pr, input logic [63:0] pl,
                               input logic [63:0] pt, input logic [63:0] pb);
    write_plane(REG_NEAR, pn);
    write_plane(REG_FAR, pf);
    write_plane(REG_RIGHT, pr);
    write_plane(REG_LEFT, pl);
    write_plane(REG_TOP, pt);
    write_plane(REG_BOTTOM, pb);
  endtask

  // Offers one item and holds it until it is taken, then idles for a random
  // gap. With no gap, valid simply stays high for the next item.
  task automatic send_item(input logic act, input logic [47:0] pa, input logic [47:0] pb,
                           input logic [15:0] rad, input logic [63:0] rot,
                           input logic [47:0] tr, input logic [47:0] sc);
    int gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_center_or_low_corner <= pa;
    in_high_corner <= pb;
    in_radius <= rad;
    in_rotation <= rot;
    in_translation <= tr;
    in_scale <= sc;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Most items are plausible scenes near the frustum; the rest are raw bits,
  // which reach every bit of every field and the extreme arithmetic.
  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 75)
        send_item(1'($urandom), near_point(16), near_point(16),
                  16'($urandom_range(0, 2048)),
                  ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : unit_quat(),
                  near_point(12),
                  {16'($urandom_range(0, 768)), 16'($urandom_range(0, 768)),
                   16'($urandom_range(0, 768))});
      else
        send_item(1'($urandom), {$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
                  16'($urandom), {$urandom, $urandom}, {$urandom, 16'($urandom)},
                  {$urandom, 16'($urandom)});
    end
  endtask

  // Waits until every expected result has arrived, then lets the pipeline
  // settle before the next register write.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [63:0] ident;
    logic [47:0] unit_sc;
    ident = {16'd16384, 48'd0};
    unit_sc = {16'd256, 16'd256, 16'd256};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset every plane has a zero normal and zero offset, so nothing
    // may be culled.
    send_random(100);
    drain();

    // An axis-aligned box frustum ten units out on each side.
    write_frustum(plane_of(0, 0, 16384, 2560), plane_of(0, 0, -16384, 2560),
                  plane_of(-16384, 0, 0, 2560), plane_of(16384, 0, 0, 2560),
                  plane_of(0, -16384, 0, 2560), plane_of(0, 16384, 0, 2560));

    // Directed items: field extremes, both volume kinds, corners in reverse
    // order, zero and maximum scale, a non-unit quaternion and spheres that
    // just touch a plane.
    send_item(1'b1, '0, '0, '0, '0, '0, '0);
    send_item(1'b0, '1, '1, '1, '1, '1, '1);
    send_item(1'b1, {16'h8000, 16'h8000, 16'h8000}, '0, 16'hffff,
              {16'h8000, 16'h8000, 16'h8000, 16'h8000}, '0, '1);
    send_item(1'b0, {16'h7fff, 16'h7fff, 16'h7fff}, {16'h8000, 16'h8000, 16'h8000},
              '0, {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
              {16'h7fff, 16'h8000, 16'h7fff}, {16'hffff, 16'hffff, 16'hffff});
    send_item(1'b0, {16'd256, 16'd256, 16'd256}, {-16'sd256, -16'sd256, -16'sd256}, '0,
              ident, '0, unit_sc);
    send_item(1'b0, {16'd3072, 16'd0, 16'd0}, {16'd3328, 16'd256, 16'd256}, '0,
              ident, '0, unit_sc);
    send_item(1'b0, {16'd3328, 16'd256, 16'd256}, {16'd2304, 16'd0, 16'd0}, '0,
              ident, '0, unit_sc);
    send_item(1'b1, {16'd3072, 16'd0, 16'd0}, '0, 16'd512, ident, '0, unit_sc);
    send_item(1'b1, {16'd3072, 16'd0, 16'd0}, '0, 16'd511, ident, '0, unit_sc);
    send_item(1'b1, {16'd3072, 16'd0, 16'd0}, '0, 16'd256, ident, '0,
              {16'd256, 16'd512, 16'd256});
    send_item(1'b1, '0, '0, '0, ident, {16'd5000, 16'd0, 16'd0}, '0);
    send_item(1'b0, {16'd9000, 16'd9000, 16'd9000}, '1, '0, ident, '0, '0);
    send_item(1'b0, '0, {16'd512, 16'd512, 16'd512}, '0,
              {16'd32767, 16'd0, 16'd0, 16'd0}, '0, unit_sc);
    send_item(1'b1, {16'd2816, 16'd0, 16'd0}, '0, 16'd256,
              {16'd11585, 16'd0, 16'd0, 16'd11585}, '0, unit_sc);
    send_item(1'b0, {16'd2304, 16'd2304, 16'd2304}, {16'd2816, 16'd2816, 16'd2816}, '0,
              {16'd11585, 16'd11585, 16'd0, 16'd0}, {-16'sd512, 16'd0, 16'd0}, unit_sc);

    // Random items, with one long hold-off on the result side while the
    // input keeps offering items.
    hold_req <= 1'b1;
    send_random(350);
    drain();

    // Random normals and offsets on every plane.
    for (int j = 0; j < NUM_PLANES; j++) write_plane(3'(j), {$urandom, $urandom});
    send_random(200);
    drain();

    // Extreme normals and offsets.
    write_frustum(plane_of(32767, 32767, 32767, 32767), plane_of(-32768, -32768, -32768, -32768),
                  plane_of(32767, -32768, 32767, -32768), plane_of(-32768, 32767, -32768, 32767),
                  plane_of(32767, 32767, -32768, 0), plane_of(-32768, 0, 32767, 32767));
    send_random(150);
    drain();

    // A zero normal with a negative offset culls every box.
    write_frustum(plane_of(0, 0, 0, 32767), plane_of(0, 0, 0, 0),
                  plane_of(0, 0, 0, -1), plane_of(0, 0, 0, 32767),
                  plane_of(0, 0, 0, 0), plane_of(0, 0, 0, 100));
    send_random(100);
    drain();

    // A perspective-like frustum with tilted side planes.
    write_frustum(plane_of(0, 0, 16384, -256), plane_of(0, 0, -16384, 5120),
                  plane_of(-11585, 0, 11585, 0), plane_of(11585, 0, 11585, 0),
                  plane_of(0, -11585, 11585, 0), plane_of(0, 11585, 11585, 0));
    send_random(230);
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
